// ----- design/ble_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ble_pkg;

    // Field widths fixed by the stream format
    localparam int VALUE_W     = 32;
    localparam int INDEX_W     = 8;
    localparam int OP_W        = 3;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 7;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_PAD_W   = OUT_TDATA_W - VALUE_W - 2 * COUNT_OUT_W;

    localparam int DEPTH_DEF   = 64;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND    = 3'd0,
        OP_INSERT    = 3'd1,
        OP_RM_VALUE  = 3'd2,
        OP_RM_INDEX  = 3'd3,
        OP_SIZE      = 3'd4,
        OP_READ      = 3'd5,
        OP_CONTAINS  = 3'd6,
        OP_FIND      = 3'd7
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_SHIFT_DN,
        S_SHIFT_UP,
        S_RESULT
    } state_t;

    // Walk engine mode: ascending read for scan and close-gap, descending for open-gap
    typedef enum logic [1:0] {
        WALK_NONE,
        WALK_SCAN,
        WALK_DOWN,
        WALK_UP
    } walk_t;

    typedef enum logic [1:0] {
        SEED_NONE,
        SEED_ZERO,
        SEED_DOWN,
        SEED_UP
    } seed_t;

    typedef enum logic [1:0] {
        POS_KEEP,
        POS_HIT,
        POS_END,
        POS_INDEX
    } pos_sel_t;

    typedef struct packed {
        logic     load;
        walk_t    walk;
        seed_t    seed;
        pos_sel_t pos_sel;
        logic     set_status;
        status_t  status;
        logic     rd_index;
        logic     put_value;
        logic     count_inc;
        logic     count_dec;
        logic     emit;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic full;
        logic idx_ok;
        logic hit;
        logic scan_end;
        logic down_done;
        logic up_done;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ----- design/bounded_list_engine.sv -----
// Ordered list engine holding up to DEPTH signed 32-bit values, head at index 0.
// Input channel (s_axis_*): one transfer carries one operation; tuser holds the
// operation code (append, sorted insert, remove value, remove index, size, read,
// contains, find index), tdata the operand value and operand index.
// Output channel (m_axis_*): exactly one result transfer per operation; tuser holds
// the status (done/found, not found or bad index, list full), tdata the value read,
// the position and the entry count after the operation.
// One operation is in flight at a time: s_axis_tready is high only while the engine
// waits for work, and it stays high even while a finished result waits to be taken.
// Each transfer is decoded first: size, read, a full list and a bad index go straight to the
// result state, append through the open-gap shift, find and contains through the search walk,
// remove by index through the close-gap shift, remove by value through the walk and, on a hit,
// the close-gap shift, and sorted insert through the walk and then the open-gap shift.
// Each stored entry costs one cycle of the list memory (one read and one write port),
// either in the search walk or in the shift that opens or closes the gap behind it.
// Reset clears the entry count and the channel state; list contents need no clearing.
// A stalled output holds its result in the output register; the engine stops in its
// result state until that register frees, and takes no new transfer meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module bounded_list_engine #(
    parameter int DEPTH = ble_pkg::DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [31:0] operand_value, [39:32] operand_index
    input  wire logic [ble_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // [2:0] operation
    input  wire logic [ble_pkg::OP_W-1:0]       s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [31:0] read_value, [38:32] position, [45:39] entry_count, [47:46] zero
    output logic [ble_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // [1:0] status
    output logic [ble_pkg::STATUS_W-1:0]        m_axis_tuser
);

    ble_pkg::cmd_t cmd;
    ble_pkg::sts_t sts;

    // Sequencer: decides each step of an operation from datapath status
    ble_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // List memory, count, walk pointers and the output register
    ble_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ----- design/ble_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ble_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire ble_pkg::sts_t sts,
    output ble_pkg::cmd_t      cmd
);

    ble_pkg::state_t state_reg;
    ble_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ble_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ble_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ble_pkg::S_DECODE;
                end
            end
            ble_pkg::S_DECODE:
            begin
                unique case (sts.op)
                    ble_pkg::OP_APPEND:
                        state_next = sts.full ? ble_pkg::S_RESULT : ble_pkg::S_SHIFT_UP;
                    ble_pkg::OP_INSERT:
                        state_next = sts.full ? ble_pkg::S_RESULT : ble_pkg::S_SCAN;
                    ble_pkg::OP_RM_VALUE,
                    ble_pkg::OP_CONTAINS,
                    ble_pkg::OP_FIND:
                        state_next = ble_pkg::S_SCAN;
                    ble_pkg::OP_RM_INDEX:
                        state_next = sts.idx_ok ? ble_pkg::S_SHIFT_DN : ble_pkg::S_RESULT;
                    ble_pkg::OP_SIZE,
                    ble_pkg::OP_READ:
                        state_next = ble_pkg::S_RESULT;
                    default:
                        state_next = ble_pkg::S_RESULT;
                endcase
            end
            ble_pkg::S_SCAN:
            begin
                priority if (sts.hit)
                begin
                    if (sts.op == ble_pkg::OP_INSERT)
                    begin
                        state_next = ble_pkg::S_SHIFT_UP;
                    end
                    else if (sts.op == ble_pkg::OP_RM_VALUE)
                    begin
                        state_next = ble_pkg::S_SHIFT_DN;
                    end
                    else
                    begin
                        state_next = ble_pkg::S_RESULT;
                    end
                end
                else if (sts.scan_end)
                begin
                    state_next = (sts.op == ble_pkg::OP_INSERT) ? ble_pkg::S_SHIFT_UP
                                                                : ble_pkg::S_RESULT;
                end
                else
                begin
                    state_next = ble_pkg::S_SCAN;
                end
            end
            ble_pkg::S_SHIFT_DN:
            begin
                if (sts.down_done)
                begin
                    state_next = ble_pkg::S_RESULT;
                end
            end
            ble_pkg::S_SHIFT_UP:
            begin
                if (sts.up_done)
                begin
                    state_next = ble_pkg::S_RESULT;
                end
            end
            ble_pkg::S_RESULT:
            begin
                if (sts.out_free)
                begin
                    state_next = ble_pkg::S_IDLE;
                end
            end
            default:
                state_next = ble_pkg::S_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ble_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ble_pkg::S_DECODE:
            begin
                unique case (sts.op)
                    ble_pkg::OP_APPEND:
                    begin
                        if (sts.full)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ble_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.pos_sel = ble_pkg::POS_END;
                            cmd.seed    = ble_pkg::SEED_UP;
                        end
                    end
                    ble_pkg::OP_INSERT:
                    begin
                        if (sts.full)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ble_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.seed = ble_pkg::SEED_ZERO;
                        end
                    end
                    ble_pkg::OP_RM_VALUE,
                    ble_pkg::OP_CONTAINS,
                    ble_pkg::OP_FIND:
                    begin
                        cmd.seed = ble_pkg::SEED_ZERO;
                    end
                    ble_pkg::OP_RM_INDEX:
                    begin
                        if (sts.idx_ok)
                        begin
                            cmd.pos_sel = ble_pkg::POS_INDEX;
                            cmd.seed    = ble_pkg::SEED_DOWN;
                        end
                        else
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ble_pkg::ST_MISS;
                        end
                    end
                    ble_pkg::OP_READ:
                    begin
                        if (sts.idx_ok)
                        begin
                            cmd.rd_index = 1'b1;
                        end
                        else
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ble_pkg::ST_MISS;
                        end
                    end
                    ble_pkg::OP_SIZE:
                    begin
                        cmd.set_status = 1'b0;
                    end
                    default:
                    begin
                        cmd.set_status = 1'b0;
                    end
                endcase
            end
            ble_pkg::S_SCAN:
            begin
                cmd.walk = ble_pkg::WALK_SCAN;
                priority if (sts.hit)
                begin
                    cmd.pos_sel = ble_pkg::POS_HIT;
                    if (sts.op == ble_pkg::OP_INSERT)
                    begin
                        cmd.seed = ble_pkg::SEED_UP;
                    end
                    else if (sts.op == ble_pkg::OP_RM_VALUE)
                    begin
                        cmd.seed = ble_pkg::SEED_DOWN;
                    end
                end
                else if (sts.scan_end)
                begin
                    if (sts.op == ble_pkg::OP_INSERT)
                    begin
                        cmd.pos_sel = ble_pkg::POS_END;
                        cmd.seed    = ble_pkg::SEED_UP;
                    end
                    else
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ble_pkg::ST_MISS;
                    end
                end
                else
                begin
                    cmd.seed = ble_pkg::SEED_NONE;
                end
            end
            ble_pkg::S_SHIFT_DN:
            begin
                cmd.walk      = ble_pkg::WALK_DOWN;
                cmd.count_dec = sts.down_done;
            end
            ble_pkg::S_SHIFT_UP:
            begin
                cmd.walk      = ble_pkg::WALK_UP;
                cmd.put_value = sts.up_done;
                cmd.count_inc = sts.up_done;
            end
            ble_pkg::S_RESULT:
            begin
                cmd.emit = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/ble_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ble_dp #(
    parameter int DEPTH = ble_pkg::DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [ble_pkg::IN_TDATA_W-1:0]    in_data,
    input  wire logic [ble_pkg::OP_W-1:0]          in_user,
    input  wire ble_pkg::cmd_t                     cmd,
    output ble_pkg::sts_t                          sts,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [ble_pkg::OUT_TDATA_W-1:0]        out_data,
    output logic [ble_pkg::STATUS_W-1:0]           out_user
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > ble_pkg::INDEX_W) ? CW : ble_pkg::INDEX_W;
    localparam int VW   = ble_pkg::VALUE_W;
    localparam int OW   = ble_pkg::COUNT_OUT_W;

    logic signed [VW-1:0]           mem [DEPTH];

    ble_pkg::op_t                   op_reg;
    logic signed [VW-1:0]           val_reg;
    logic [ble_pkg::INDEX_W-1:0]    idx_reg;
    ble_pkg::status_t               status_reg;
    logic [CW-1:0]                  pos_reg;
    logic [CW-1:0]                  pos_next;
    logic [CW-1:0]                  count_reg;
    logic [CW-1:0]                  ptr_reg;
    logic [CW-1:0]                  ptr_next;
    logic [CW-1:0]                  chk_ptr_reg;
    logic [CW-1:0]                  chk_ptr_next;
    logic                           chk_vld_reg;
    logic                           chk_vld_next;
    logic signed [VW-1:0]           rdata_reg;
    logic                           out_valid_reg;
    logic [ble_pkg::OUT_TDATA_W-1:0] out_data_reg;
    logic [ble_pkg::STATUS_W-1:0]   out_user_reg;

    logic                           scan_more;
    logic                           up_more;
    logic                           issue;
    logic [CW-1:0]                  walk_addr;
    logic [CW-1:0]                  ptr_step;
    logic [CW-1:0]                  chk_below;
    logic [CW-1:0]                  chk_above;
    logic                           rd_en;
    logic [AW-1:0]                  rd_addr;
    logic                           wr_en;
    logic [AW-1:0]                  wr_addr;
    logic signed [VW-1:0]           wr_data;
    logic                           scan_match;
    logic                           show_pos;
    logic signed [VW-1:0]           rv_out;
    logic [OW-1:0]                  pos_out;
    logic                           out_free;

    // Walk engine: one stored entry per cycle, read data is registered and returns in the next cycle
    assign scan_more = ptr_reg < count_reg;
    assign up_more   = ptr_reg > pos_reg;
    assign chk_below = chk_ptr_reg - CW'(1);
    assign chk_above = chk_ptr_reg + CW'(1);

    always_comb
    begin
        issue     = 1'b0;
        walk_addr = ptr_reg;
        ptr_step  = ptr_reg;
        unique case (cmd.walk)
            ble_pkg::WALK_NONE:
            begin
                issue = 1'b0;
            end
            ble_pkg::WALK_SCAN,
            ble_pkg::WALK_DOWN:
            begin
                issue     = scan_more;
                walk_addr = ptr_reg;
                ptr_step  = ptr_reg + CW'(1);
            end
            ble_pkg::WALK_UP:
            begin
                issue     = up_more;
                walk_addr = ptr_reg - CW'(1);
                ptr_step  = ptr_reg - CW'(1);
            end
            default:
            begin
                issue = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        unique case (cmd.pos_sel)
            ble_pkg::POS_KEEP:  pos_next = pos_reg;
            ble_pkg::POS_HIT:   pos_next = chk_ptr_reg;
            ble_pkg::POS_END:   pos_next = count_reg;
            ble_pkg::POS_INDEX: pos_next = CW'(idx_reg);
            default:            pos_next = pos_reg;
        endcase
    end

    always_comb
    begin
        ptr_next     = ptr_reg;
        chk_ptr_next = chk_ptr_reg;
        chk_vld_next = 1'b0;
        unique case (cmd.seed)
            ble_pkg::SEED_ZERO:
                ptr_next = '0;
            ble_pkg::SEED_DOWN:
                ptr_next = pos_next + CW'(1);
            ble_pkg::SEED_UP:
                ptr_next = count_reg;
            ble_pkg::SEED_NONE:
            begin
                if (issue)
                begin
                    ptr_next     = ptr_step;
                    chk_ptr_next = walk_addr;
                    chk_vld_next = 1'b1;
                end
            end
            default:
                ptr_next = ptr_reg;
        endcase
    end

    // Memory ports: one read, one write per cycle
    assign rd_en   = cmd.rd_index | issue;
    assign rd_addr = cmd.rd_index ? AW'(idx_reg) : walk_addr[AW-1:0];

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = chk_ptr_reg[AW-1:0];
        wr_data = rdata_reg;
        priority if (cmd.put_value)
        begin
            wr_en   = 1'b1;
            wr_addr = pos_reg[AW-1:0];
            wr_data = val_reg;
        end
        else if (chk_vld_reg && cmd.walk == ble_pkg::WALK_DOWN)
        begin
            wr_en   = 1'b1;
            wr_addr = chk_below[AW-1:0];
        end
        else if (chk_vld_reg && cmd.walk == ble_pkg::WALK_UP)
        begin
            wr_en   = 1'b1;
            wr_addr = chk_above[AW-1:0];
        end
        else
        begin
            wr_en = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Compare: equality for searches, placement rule for sorted insert
    always_comb
    begin
        if (op_reg == ble_pkg::OP_INSERT)
        begin
            if (chk_ptr_reg == '0)
            begin
                scan_match = val_reg < rdata_reg;
            end
            else
            begin
                scan_match = !(rdata_reg < val_reg);
            end
        end
        else
        begin
            scan_match = rdata_reg == val_reg;
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        sts.op        = op_reg;
        sts.full      = count_reg == CW'(DEPTH);
        sts.idx_ok    = CMPW'(idx_reg) < CMPW'(count_reg);
        sts.hit       = chk_vld_reg && scan_match;
        sts.scan_end  = !scan_more && !chk_vld_reg;
        sts.down_done = !scan_more && !chk_vld_reg;
        sts.up_done   = !up_more && !chk_vld_reg;
        sts.out_free  = out_free;
    end

    // Result fields
    assign show_pos = (status_reg == ble_pkg::ST_OK) &&
                      (op_reg == ble_pkg::OP_APPEND || op_reg == ble_pkg::OP_INSERT ||
                       op_reg == ble_pkg::OP_RM_VALUE || op_reg == ble_pkg::OP_RM_INDEX ||
                       op_reg == ble_pkg::OP_FIND);
    assign pos_out  = show_pos ? OW'(pos_reg) : '0;
    assign rv_out   = (status_reg == ble_pkg::ST_OK && op_reg == ble_pkg::OP_READ) ? rdata_reg
                                                                                    : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            chk_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            chk_vld_reg <= chk_vld_next;
            if (cmd.count_inc)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.count_dec)
            begin
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg     <= ptr_next;
        chk_ptr_reg <= chk_ptr_next;
        pos_reg     <= pos_next;
        if (cmd.load)
        begin
            op_reg     <= ble_pkg::op_t'(in_user);
            val_reg    <= in_data[VW-1:0];
            idx_reg    <= in_data[VW +: ble_pkg::INDEX_W];
            status_reg <= ble_pkg::ST_OK;
        end
        else if (cmd.set_status)
        begin
            status_reg <= cmd.status;
        end
        if (cmd.emit)
        begin
            out_data_reg <= {{ble_pkg::OUT_PAD_W{1'b0}}, OW'(count_reg), pos_out, rv_out};
            out_user_reg <= status_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;

endmodule

`default_nettype wire

// ----- design/ble_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ble_chk #(
    parameter int DEPTH = ble_pkg::DEPTH_DEF
) (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [ble_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic [ble_pkg::STATUS_W-1:0]   m_axis_tuser
);

    localparam int OW = ble_pkg::COUNT_OUT_W;

    // One operation at a time: drop ready after every input transfer
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an operation was in flight");

    // A fresh result only follows a busy period of the engine
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without an operation in progress");

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // A full report carries the full count, no position and no value
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == ble_pkg::ST_FULL |->
            m_axis_tdata[32 + 2 * OW - 1 : 32 + OW] == OW'(DEPTH) &&
            m_axis_tdata[32 + OW - 1 : 0] == '0)
        else $error("full status with wrong count or payload");

endmodule

bind bounded_list_engine ble_chk #(
    .DEPTH (DEPTH)
) u_ble_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ----- tb/tb_bounded_list_engine.sv -----
`timescale 1ns / 1ps

module tb_bounded_list_engine;

    import ble_pkg::*;

    localparam int LIST_DEPTH   = DEPTH_DEF;
    localparam int RANDOM_OPS   = 1230;
    localparam int PHASE_LEN    = 150;   // transfers per pacing phase
    localparam int LONG_HOLD    = 400;   // cycles of output back-pressure
    localparam int STALL_LIMIT  = 5000;  // cycles without any transfer
    localparam int TAIL_CYCLES  = 200;   // cycles idled after the last result
    localparam int N_DIRECTED   = 22;

    typedef enum logic [1:0] {
        PACE_FREE,
        PACE_SEND_IDLE,
        PACE_RECV_STALL,
        PACE_BOTH
    } pace_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] rval;
        logic [6:0]  pos;
        logic [6:0]  cnt;
    } outcome_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] v;
        logic [7:0]  idx;
        logic        typed;  // expectation written out below, not predicted
        outcome_t    want;
    } plan_row_t;

    localparam outcome_t NO_WANT = '{ST_OK, 32'd0, 7'd0, 7'd0};

    // Opening sequence: empty-list queries, sorted insert at the head,
    // extremes of value and index, a stored minus one read back.
    localparam plan_row_t PLAN [N_DIRECTED] = '{
        '{OP_SIZE,      32'd0,          8'd0,   1'b1, '{ST_OK,   32'd0, 7'd0, 7'd0}},
        '{OP_READ,      32'd0,          8'd0,   1'b1, '{ST_MISS, 32'd0, 7'd0, 7'd0}},
        '{OP_RM_INDEX,  32'd0,          8'd255, 1'b1, '{ST_MISS, 32'd0, 7'd0, 7'd0}},
        '{OP_RM_VALUE,  32'd5,          8'd0,   1'b1, '{ST_MISS, 32'd0, 7'd0, 7'd0}},
        '{OP_FIND,      32'd0,          8'd0,   1'b1, '{ST_MISS, 32'd0, 7'd0, 7'd0}},
        '{OP_CONTAINS,  32'd0,          8'd0,   1'b1, '{ST_MISS, 32'd0, 7'd0, 7'd0}},
        '{OP_INSERT,    32'h7fff_ffff,  8'd0,   1'b1, '{ST_OK,   32'd0, 7'd0, 7'd1}},
        '{OP_INSERT,    32'h8000_0000,  8'd0,   1'b1, '{ST_OK,   32'd0, 7'd0, 7'd2}},
        '{OP_APPEND,    32'hffff_ffff,  8'd0,   1'b1, '{ST_OK,   32'd0, 7'd2, 7'd3}},
        '{OP_READ,      32'd0,          8'd2,   1'b1,
          '{ST_OK, 32'hffff_ffff, 7'd0, 7'd3}},
        '{OP_INSERT,    32'd0,          8'd0,   1'b0, NO_WANT},
        '{OP_INSERT,    32'h7fff_ffff,  8'd0,   1'b0, NO_WANT},
        '{OP_FIND,      32'hffff_ffff,  8'd0,   1'b0, NO_WANT},
        '{OP_CONTAINS,  32'h8000_0000,  8'd0,   1'b0, NO_WANT},
        '{OP_READ,      32'd0,          8'd255, 1'b1, '{ST_MISS, 32'd0, 7'd0, 7'd5}},
        '{OP_RM_VALUE,  32'h7fff_ffff,  8'd0,   1'b0, NO_WANT},
        '{OP_RM_INDEX,  32'd0,          8'd0,   1'b0, NO_WANT},
        '{OP_SIZE,      32'd0,          8'd0,   1'b0, NO_WANT},
        '{OP_APPEND,    32'h5a5a_5a5a,  8'd0,   1'b0, NO_WANT},
        '{OP_RM_INDEX,  32'd0,          8'd3,   1'b0, NO_WANT},
        '{OP_INSERT,    32'hffff_ffff,  8'd0,   1'b0, NO_WANT},
        '{OP_READ,      32'd0,          8'd0,   1'b0, NO_WANT}
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [31:0] operand_value, [39:32] operand_index
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // [2:0] operation
    logic [OP_W-1:0]        s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [31:0] read_value, [38:32] position, [45:39] entry_count, [47:46] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // [1:0] status
    logic [STATUS_W-1:0]    m_axis_tuser;

    bounded_list_engine #(.DEPTH(LIST_DEPTH)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Shadow copy of the list, kept in step with accepted operations
    logic [31:0] list_mem [LIST_DEPTH];
    int          list_len = 0;

    outcome_t    outcomes_due [$];
    int          mismatches = 0;
    pace_t       pace = PACE_FREE;
    bit          hold_request = 1'b0;
    bit          growing = 1'b1;

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Apply one operation to the shadow list and return the result it owes
    function automatic outcome_t apply_list_op(op_t op, logic [31:0] v, logic [7:0] idx);
        outcome_t r;
        int       hit;
        int       at;
        r = NO_WANT;
        hit = -1;
        for (int i = 0; i < list_len; i++)
        begin
            if (hit < 0 && list_mem[i] == v)
                hit = i;
        end
        case (op)
            OP_APPEND:
            begin
                if (list_len >= LIST_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    r.pos = 7'(list_len);
                    list_mem[list_len] = v;
                    list_len++;
                end
            end
            OP_INSERT:
            begin
                if (list_len >= LIST_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    at = 0;
                    // below the head goes first; otherwise before the first
                    // entry from index 1 on that is not smaller
                    if (list_len != 0 && !($signed(v) < $signed(list_mem[0])))
                    begin
                        at = list_len;
                        for (int j = list_len - 1; j >= 1; j--)
                        begin
                            if (!($signed(list_mem[j]) < $signed(v)))
                                at = j;
                        end
                    end
                    for (int j = list_len; j > at; j--)
                        list_mem[j] = list_mem[j - 1];
                    list_mem[at] = v;
                    list_len++;
                    r.pos = 7'(at);
                end
            end
            OP_RM_VALUE, OP_RM_INDEX:
            begin
                at = (op == OP_RM_VALUE) ? hit : ((int'(idx) < list_len) ? int'(idx) : -1);
                if (at < 0)
                    r.status = ST_MISS;
                else
                begin
                    r.pos = 7'(at);
                    for (int j = at; j + 1 < list_len; j++)
                        list_mem[j] = list_mem[j + 1];
                    list_len--;
                end
            end
            OP_READ:
            begin
                if (int'(idx) >= list_len)
                    r.status = ST_MISS;
                else
                    r.rval = list_mem[idx];
            end
            OP_CONTAINS:
            begin
                if (hit < 0)
                    r.status = ST_MISS;
            end
            OP_FIND:
            begin
                if (hit < 0)
                    r.status = ST_MISS;
                else
                    r.pos = 7'(hit);
            end
            default: ;
        endcase
        r.cnt = 7'(list_len);
        return r;
    endfunction

    // Offer one operation, hold it until transferred, then log what it owes
    task automatic offer_op(input op_t op, input logic [31:0] v, input logic [7:0] idx,
                            input logic typed, input outcome_t want);
        outcome_t predicted;
        int       gap_pct;
        gap_pct = (pace == PACE_SEND_IDLE) ? 61 : (pace == PACE_BOTH) ? 34 : 0;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {idx, v};
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = apply_list_op(op, v, idx);
        outcomes_due.push_back(typed ? want : predicted);
    endtask

    // Random operation, biased to fill the list up to full and drain it again
    task automatic pick_random_op(output op_t op, output logic [31:0] v,
                                  output logic [7:0] idx);
        int unsigned roll;
        int unsigned kind;
        if (list_len == LIST_DEPTH)
            growing = 1'b0;
        else if (list_len == 0 || $urandom_range(0, 59) == 0)
            growing = (list_len == 0) ? 1'b1 : ~growing;
        roll = $urandom_range(0, 99);
        if (roll < (growing ? 35 : 10))
            op = OP_APPEND;
        else if (roll < (growing ? 65 : 18))
            op = OP_INSERT;
        else if (roll < (growing ? 75 : 45))
            op = OP_RM_VALUE;
        else if (roll < (growing ? 83 : 70))
            op = OP_RM_INDEX;
        else
        begin
            case ($urandom_range(0, 3))
                0:       op = OP_SIZE;
                1:       op = OP_READ;
                2:       op = OP_CONTAINS;
                default: op = OP_FIND;
            endcase
        end
        // half the values already held, so searches hit; the rest clustered, extreme or random
        kind = $urandom_range(0, 9);
        if (kind < 5 && list_len > 0)
            v = list_mem[$urandom_range(0, list_len - 1)];
        else if (kind < 7)
            v = 32'($signed($urandom_range(0, 8)) - 4);
        else if (kind == 7)
        begin
            case ($urandom_range(0, 3))
                0:       v = 32'h8000_0000;
                1:       v = 32'h7fff_ffff;
                2:       v = 32'hffff_ffff;
                default: v = 32'd0;
            endcase
        end
        else
            v = $urandom;
        idx = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, list_len))
                                          : 8'($urandom_range(0, 255));
    endtask

    // Stimulus: reset, directed table, then paced random phases
    initial
    begin
        op_t         op;
        logic [31:0] v;
        logic [7:0]  idx;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < N_DIRECTED; i++)
            offer_op(PLAN[i].op, PLAN[i].v, PLAN[i].idx, PLAN[i].typed, PLAN[i].want);
        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            pace = pace_t'((n / PHASE_LEN) % 4);
            // one long output hold-off mid-run, with input still offered
            if (n == RANDOM_OPS / 2)
                hold_request = 1'b1;
            pick_random_op(op, v, idx);
            offer_op(op, v, idx, 1'b0, NO_WANT);
        end
        s_axis_tvalid <= 1'b0;
        while (outcomes_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Result side: check each transfer, then choose the next tready
    initial
    begin
        outcome_t seen;
        outcome_t want;
        int       hold_left;
        int       stall_pct;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                seen.status = status_t'(m_axis_tuser);
                seen.rval   = m_axis_tdata[31:0];
                seen.pos    = m_axis_tdata[38:32];
                seen.cnt    = m_axis_tdata[45:39];
                if (outcomes_due.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    mismatches++;
                end
                else
                begin
                    want = outcomes_due.pop_front();
                    if (seen.status != want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, seen.status);
                        mismatches++;
                    end
                    if (seen.rval != want.rval)
                    begin
                        $error("read_value: expected %0d, got %0d",
                               $signed(want.rval), $signed(seen.rval));
                        mismatches++;
                    end
                    if (seen.pos != want.pos)
                    begin
                        $error("position: expected %0d, got %0d", want.pos, seen.pos);
                        mismatches++;
                    end
                    if (seen.cnt != want.cnt)
                    begin
                        $error("entry_count: expected %0d, got %0d", want.cnt, seen.cnt);
                        mismatches++;
                    end
                end
            end
            stall_pct = (pace == PACE_RECV_STALL) ? 61 : (pace == PACE_BOTH) ? 34 : 0;
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Watchdog: give up once no transfer has happened for too long
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

endmodule
